>>> rtl/core/lrs_pkg.sv
// lrs_pkg: shared widths and payload types for the lru replacement store
// depends on nothing; imported by every module of the block
package lrs_pkg;

   localparam int KEY_BITS     = 16;
   localparam int SLOT_BITS    = 3;
   localparam int CFG_BITS     = 4;
   localparam int DEFAULT_WAYS = 8;

   typedef struct packed {
      logic [KEY_BITS-1:0] request_key;
      logic                last_request;
   } req_payload_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      logic                 evicted_valid;
      logic [KEY_BITS-1:0]  evicted_key;
      logic                 last_result;
   } rsp_payload_type;

endpackage

>>> rtl/core/lrs_lookup.sv
// lrs_lookup: parallel tag compare, empty-slot search and lru victim choice
// depends on lrs_pkg
module lrs_lookup #(
   parameter int WAYS      = lrs_pkg::DEFAULT_WAYS,
   parameter int RANK_BITS = 3
) (
   input  logic [WAYS-1:0][lrs_pkg::KEY_BITS-1:0] keys,
   input  logic [WAYS-1:0][RANK_BITS-1:0]         ranks,
   input  logic [WAYS-1:0]                        in_use,
   input  logic [lrs_pkg::KEY_BITS-1:0]           key,
   output logic [WAYS-1:0]                        pick_onehot,
   output logic                                   hit,
   output logic                                   evict
);
   import lrs_pkg::*;

   logic [WAYS-1:0] match_vec;
   logic [WAYS-1:0] empty_vec;
   logic [WAYS-1:0] oldest_vec;
   logic [WAYS-1:0] match_first;
   logic [WAYS-1:0] empty_first;
   logic            any_empty;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         match_vec[i] = in_use[i] && (keys[i] == key);
         empty_vec[i] = in_use[i] && (keys[i] == '0);
      end
   end

   // lowest set bit wins
   assign match_first = match_vec & (~match_vec + WAYS'(1));
   assign empty_first = empty_vec & (~empty_vec + WAYS'(1));
   assign any_empty   = |empty_vec;

   // slot i is the victim when it is strictly older than every lower slot
   // and at least as old as every higher slot in use
   always_comb begin
      logic older;
      for (int i = 0; i < WAYS; i++) begin
         older = in_use[i];
         for (int j = 0; j < WAYS; j++) begin
            if (j < i && ranks[i] <= ranks[j]) begin
               older = 1'b0;
            end
            if (j > i && in_use[j] && ranks[i] < ranks[j]) begin
               older = 1'b0;
            end
         end
         oldest_vec[i] = older;
      end
   end

   assign hit   = |match_vec;
   assign evict = !hit && !any_empty;

   always_comb begin
      if (hit) begin
         pick_onehot = match_first;
      end else if (any_empty) begin
         pick_onehot = empty_first;
      end else begin
         pick_onehot = oldest_vec;
      end
   end

endmodule

>>> rtl/core/lrs_entries.sv
// lrs_entries: resident key and recency rank registers with their update
// depends on lrs_pkg
module lrs_entries #(
   parameter int WAYS      = lrs_pkg::DEFAULT_WAYS,
   parameter int RANK_BITS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   update,
   input  logic                                   clear,
   input  logic [WAYS-1:0]                        in_use,
   input  logic [WAYS-1:0]                        pick_onehot,
   input  logic                                   hit,
   input  logic [lrs_pkg::KEY_BITS-1:0]           key,
   output logic [WAYS-1:0][lrs_pkg::KEY_BITS-1:0] keys,
   output logic [WAYS-1:0][RANK_BITS-1:0]         ranks
);
   import lrs_pkg::*;

   localparam logic [RANK_BITS-1:0] RankMax = RANK_BITS'(WAYS - 1);

   logic [WAYS-1:0][KEY_BITS-1:0]  keys_ff;
   logic [WAYS-1:0][KEY_BITS-1:0]  keys_in;
   logic [WAYS-1:0][RANK_BITS-1:0] ranks_ff;
   logic [WAYS-1:0][RANK_BITS-1:0] ranks_in;
   logic [RANK_BITS-1:0]           limit_rank;

   // rank of the hit slot: on a hit only younger entries age
   always_comb begin
      limit_rank = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (pick_onehot[i]) begin
            limit_rank = limit_rank | ranks_ff[i];
         end
      end
   end

   always_comb begin
      keys_in  = keys_ff;
      ranks_in = ranks_ff;
      if (clear) begin
         keys_in  = '0;
         ranks_in = '0;
      end else if (update) begin
         for (int i = 0; i < WAYS; i++) begin
            if (pick_onehot[i]) begin
               keys_in[i]  = key;
               ranks_in[i] = '0;
            end else if (in_use[i] && keys_ff[i] != '0
                         && (!hit || ranks_ff[i] < limit_rank)
                         && ranks_ff[i] < RankMax) begin
               ranks_in[i] = ranks_ff[i] + RANK_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff  <= '0;
         ranks_ff <= '0;
      end else begin
         keys_ff  <= keys_in;
         ranks_ff <= ranks_in;
      end
   end

   assign keys  = keys_ff;
   assign ranks = ranks_ff;

endmodule

>>> rtl/core/lru_replacement_store_core.sv
// lru_replacement_store_core: fully associative key store with lru replacement
// a result strobes after start once the request has passed the input register, then the result register
// throughput: one item per cycle; busy is never raised and results cannot be stalled
// the throughput is set by the combinational compare and the rank update over all slots
// reset clears every slot and rank and sets the way count to WAYS
// depends on lrs_pkg, lrs_lookup, lrs_entries
module lru_replacement_store_core #(
   parameter int WAYS = lrs_pkg::DEFAULT_WAYS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lrs_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   output lrs_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lrs_pkg::CFG_BITS-1:0]  csr_wdata
);
   import lrs_pkg::*;

   localparam int RANK_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int COUNT_BITS = ($clog2(WAYS + 1) > CFG_BITS) ? $clog2(WAYS + 1) : CFG_BITS;

   logic [COUNT_BITS-1:0]          ways_ff;
   logic                           req_valid_ff;
   req_payload_type                req_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   rsp_payload_type                rsp_ff;
   rsp_payload_type                rsp_in;

   logic [WAYS-1:0]                in_use;
   logic [WAYS-1:0][KEY_BITS-1:0]  keys;
   logic [WAYS-1:0][RANK_BITS-1:0] ranks;
   logic [WAYS-1:0]                pick_onehot;
   logic                           hit;
   logic                           evict;
   logic                           key_nonzero;
   logic                           do_update;
   logic [RANK_BITS-1:0]           pick_index;
   logic [KEY_BITS-1:0]            victim_key;
   logic [SLOT_BITS+RANK_BITS-1:0] slot_ext;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= COUNT_BITS'(WAYS);
      end else if (csr_valid && csr_ready) begin
         ways_ff <= COUNT_BITS'(csr_wdata);
      end
   end

   // a way count of zero still uses slot zero; counts above WAYS use all slots
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         if (ways_ff == '0) begin
            in_use[i] = (i == 0);
         end else begin
            in_use[i] = (i < int'(ways_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_payload;
      end
   end

   lrs_lookup #(
      .WAYS      (WAYS),
      .RANK_BITS (RANK_BITS)
   ) u_lookup (
      .keys        (keys),
      .ranks       (ranks),
      .in_use      (in_use),
      .key         (req_ff.request_key),
      .pick_onehot (pick_onehot),
      .hit         (hit),
      .evict       (evict)
   );

   assign key_nonzero = (req_ff.request_key != '0);
   assign do_update   = req_valid_ff && key_nonzero;

   lrs_entries #(
      .WAYS      (WAYS),
      .RANK_BITS (RANK_BITS)
   ) u_entries (
      .clock       (clock),
      .reset       (reset),
      .update      (do_update),
      .clear       (req_valid_ff && req_ff.last_request),
      .in_use      (in_use),
      .pick_onehot (pick_onehot),
      .hit         (hit),
      .key         (req_ff.request_key),
      .keys        (keys),
      .ranks       (ranks)
   );

   always_comb begin
      pick_index = '0;
      victim_key = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (pick_onehot[i]) begin
            pick_index = pick_index | RANK_BITS'(i);
            victim_key = victim_key | keys[i];
         end
      end
   end

   assign slot_ext = {{SLOT_BITS{1'b0}}, pick_index};

   // a zero key is no lookup and reports zeros in every field but last_result
   always_comb begin
      rsp_in.hit           = key_nonzero && hit;
      rsp_in.slot          = key_nonzero ? slot_ext[SLOT_BITS-1:0] : '0;
      rsp_in.evicted_valid = key_nonzero && evict;
      rsp_in.evicted_key   = (key_nonzero && evict) ? victim_key : '0;
      rsp_in.last_result   = req_ff.last_request;
   end

   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      do_update |-> $onehot(pick_onehot))
      else $error("slot selection is not one-hot");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> !rsp_payload.evicted_valid)
      else $error("hit reported together with an eviction");

   a_evict_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.evicted_valid |-> rsp_payload.evicted_key != '0)
      else $error("eviction of an empty slot");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_ff.last_request |=> keys == '0 && ranks == '0)
      else $error("store not cleared after the last item");

endmodule

>>> tb/sv/lru_store_monitor.sv
// lru_store_monitor: watches the request, result and csr channels of the lru store,
// predicts every result from its own copy of the slots and ranks, and counts mismatches
// depends on lrs_pkg
module lru_store_monitor #(
   parameter int WAYS = lrs_pkg::DEFAULT_WAYS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  lrs_pkg::req_payload_type      req_payload,
   input  logic                          rsp_valid,
   input  lrs_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [lrs_pkg::CFG_BITS-1:0]  csr_wdata,
   output int                            mismatch_count,
   output int                            pending_count
);
   import lrs_pkg::*;

   logic [KEY_BITS-1:0]  resident [WAYS];
   int unsigned          age_rank [WAYS];
   int unsigned          way_count;
   rsp_payload_type      expected_results [$];

   initial mismatch_count = 0;
   initial pending_count  = 0;

   function automatic void clear_store();
      for (int i = 0; i < WAYS; i++) begin
         resident[i] = '0;
         age_rank[i] = 0;
      end
   endfunction

   // one lookup with lru update; returns the result the block should report
   function automatic rsp_payload_type lookup_and_update(input req_payload_type item);
      rsp_payload_type res;
      int unsigned     n;
      int unsigned     where;
      int unsigned     age_limit;
      bit              found;
      bit              empty;
      res = '0;
      res.last_result = item.last_request;
      n = (way_count == 0) ? 1 : ((way_count > WAYS) ? WAYS : way_count);
      where = 0;
      found = 0;
      empty = 0;
      if (item.request_key != '0) begin
         for (int i = 0; i < n; i++) begin
            if (!found && resident[i] == item.request_key) begin
               found = 1;
               where = i;
            end
         end
         if (found) begin
            res.hit = 1'b1;
            age_limit = age_rank[where];
         end else begin
            for (int i = 0; i < n; i++) begin
               if (!empty && resident[i] == '0) begin
                  empty = 1;
                  where = i;
               end
            end
            if (!empty) begin
               // oldest rank wins, lowest index on ties
               where = 0;
               for (int i = 1; i < n; i++)
                  if (age_rank[i] > age_rank[where]) where = i;
               res.evicted_valid = 1'b1;
               res.evicted_key   = resident[where];
            end
            resident[where] = item.request_key;
            age_limit = 256;
         end
         for (int i = 0; i < n; i++) begin
            if (i != where && resident[i] != '0 && age_rank[i] < age_limit &&
                age_rank[i] < WAYS - 1)
               age_rank[i]++;
         end
         age_rank[where] = 0;
         res.slot = where[SLOT_BITS-1:0];
      end
      if (item.last_request) clear_store();
      return res;
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_store();
         way_count = WAYS;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding, expected none, actual %0h",
                        $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("hit", want.hit, rsp_payload.hit);
               compare_field("slot", want.slot, rsp_payload.slot);
               compare_field("evicted_valid", want.evicted_valid, rsp_payload.evicted_valid);
               compare_field("evicted_key", want.evicted_key, rsp_payload.evicted_key);
               compare_field("last_result", want.last_result, rsp_payload.last_result);
            end
         end
         if (csr_valid && csr_ready) way_count = csr_wdata;
         if (start && !busy) expected_results.push_back(lookup_and_update(req_payload));
      end
      pending_count <= expected_results.size();
   end

endmodule

>>> tb/sv/lru_replacement_store_core_tb.sv
// lru_replacement_store_core_tb: drives request lists and way-count writes into the
// lru store and gives the verdict; depends on lrs_pkg, lru_store_monitor and the block
module lru_replacement_store_core_tb;
   import lrs_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_BITS-1:0]  csr_wdata = '0;
   int                   mismatch_count;
   int                   pending_count;
   int                   cycle_count = 0;
   int                   random_sent = 0;
   bit                   idle_on = 1;

   lru_replacement_store_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   lru_store_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_replacement_store_core_tb: errors");
         $finish;
      end
   end

   task automatic send_request(input logic [KEY_BITS-1:0] key, input logic last);
      req_payload_type item;
      int              gap;
      item.request_key  = key;
      item.last_request = last;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
   endtask

   // stop issuing and wait until every outstanding item has its result
   task automatic settle_store();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_way_count(input logic [CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CFG_BITS-1:0] pick_way_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return CFG_BITS'($urandom_range(9, 15));
      return CFG_BITS'($urandom_range(1, 8));
   endfunction

   // one list of requests drawn mostly from a small key pool so hits and evictions occur
   task automatic run_request_list(input logic [CFG_BITS-1:0] ways);
      logic [KEY_BITS-1:0] key_pool [$];
      logic [KEY_BITS-1:0] key;
      int                  pool_size;
      int                  length;
      int                  change_at;
      int                  r;
      bit                  ends_list;
      settle_store();
      write_way_count(ways);
      idle_on   = ($urandom_range(0, 3) != 0);
      pool_size = ((ways == 0) ? 1 : ((ways > 8) ? 8 : ways)) + $urandom_range(0, 4);
      for (int i = 0; i < pool_size; i++)
         key_pool.push_back(KEY_BITS'($urandom_range(1, 65535)));
      length    = $urandom_range(1, 40);
      change_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, length - 1) : -1;
      ends_list = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < length; i++) begin
         if (i == change_at) begin
            // way count moves while entries are still resident
            settle_store();
            write_way_count(pick_way_count());
         end
         r = $urandom_range(0, 99);
         if (r < 5) key = '0;
         else if (r < 15) key = KEY_BITS'($urandom_range(0, 65535));
         else key = key_pool[$urandom_range(0, pool_size - 1)];
         send_request(key, (i == length - 1) ? ends_list : 1'b0);
         if (key != '0) random_sent++;
      end
   endtask

   initial begin
      logic [CFG_BITS-1:0] way_extremes [4];
      int                  list_index;
      way_extremes = '{4'd0, 4'd15, 4'd8, 4'd1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset way count: fill every slot, hit the oldest, evict, zero key, end the list
      send_request(16'h0001, 1'b0);
      send_request(16'hFFFF, 1'b0);
      for (int k = 3; k <= 8; k++) send_request(KEY_BITS'(k), 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'h0009, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0005, 1'b1);
      send_request(16'h0000, 1'b1);

      // single slot: after the first fill every new key evicts the one before it
      settle_store();
      write_way_count(4'd1);
      send_request(16'h000A, 1'b0);
      send_request(16'h000B, 1'b0);
      send_request(16'h000B, 1'b0);
      send_request(16'h8000, 1'b0);
      send_request(16'h0000, 1'b1);

      list_index = 0;
      while (random_sent < RANDOM_ITEMS) begin
         run_request_list((list_index < 4) ? way_extremes[list_index] : pick_way_count());
         list_index++;
      end

      settle_store();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("lru_replacement_store_core_tb: clean");
      end else begin
         $display("lru_replacement_store_core_tb: errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/lrs_pkg.sv
rtl/core/lrs_lookup.sv
rtl/core/lrs_entries.sv
rtl/core/lru_replacement_store_core.sv
tb/sv/lru_store_monitor.sv
tb/sv/lru_replacement_store_core_tb.sv
